@@ hw/rtl/prc_pkg.sv @@
// prc_pkg: shared types, widths and register indexes for the pixel color replace block.
// No dependencies; every module of the block imports it.

package prc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_BLEND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS       = 3'd4;

    // datapath widths
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int RAD_W   = 9;
    localparam int DIFF_W  = CH_W + 1;
    localparam int SQ_W    = 2 * CH_W;
    localparam int DIST_W  = SQ_W + 2;          // sum of three squares
    localparam int FRAC_W  = 16;                // blend factor fraction bits
    localparam int P_W     = FRAC_W + 1;        // factor 0..1.0 inclusive
    localparam int ROOT_W  = (DIST_W + 2 * FRAC_W + 1) / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;         // one root bit per stage
    localparam int DIV_STEPS  = P_W;            // one quotient bit per stage
    localparam int PROD_W  = P_W + 1 + DIFF_W;
    localparam int NUM_W   = PROD_W + 1;

    localparam logic [P_W-1:0] P_ONE = P_W'(1) << FRAC_W;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_out_word;

    // what travels beside the arithmetic down the pipe
    typedef struct packed {
        logic     hard;     // replace with target color
        logic     blend;    // blend toward target by distance
        t_in_word pix;
    } t_side;

endpackage

@@ hw/rtl/prc_dist.sv @@
// prc_dist: two stages, squared channel distances to the key color, then sum and radius test.
// Depends on prc_pkg.

module prc_dist
    import prc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  t_in_word           i_word,
    input  logic [COLOR_W-1:0] i_key_color,
    input  logic [RAD_W-1:0]   i_match_radius,
    input  logic               i_soft_blend,
    input  logic               i_bypass,
    output logic               o_valid,
    output t_side              o_side,
    output logic [DIST_W-1:0]  o_dist2
);

    logic signed [DIFF_W-1:0]   w_rd, w_gd, w_bd;
    logic signed [2*DIFF_W-1:0] w_rsq, w_gsq, w_bsq;
    logic [DIST_W-1:0]          w_sum, w_rad2;
    logic                       w_match, w_rad_zero;

    logic            r_v1;
    t_in_word        r_pix1;
    logic [SQ_W-1:0] r_sq_r, r_sq_g, r_sq_b;

    logic              r_v2;
    t_side             r_side2;
    logic [DIST_W-1:0] r_dist2;

    assign w_rd = $signed({1'b0, i_word.in_red})   - $signed({1'b0, i_key_color[23:16]});
    assign w_gd = $signed({1'b0, i_word.in_green}) - $signed({1'b0, i_key_color[15:8]});
    assign w_bd = $signed({1'b0, i_word.in_blue})  - $signed({1'b0, i_key_color[7:0]});

    assign w_rsq = w_rd * w_rd;
    assign w_gsq = w_gd * w_gd;
    assign w_bsq = w_bd * w_bd;

    assign w_sum = {2'b00, r_sq_r} + {2'b00, r_sq_g} + {2'b00, r_sq_b};
    assign w_rad2 = {{(DIST_W-RAD_W){1'b0}}, i_match_radius}
                  * {{(DIST_W-RAD_W){1'b0}}, i_match_radius};
    assign w_match    = (w_sum <= w_rad2);
    assign w_rad_zero = (i_match_radius == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix1 <= i_word;
            r_sq_r <= w_rsq[SQ_W-1:0];
            r_sq_g <= w_gsq[SQ_W-1:0];
            r_sq_b <= w_bsq[SQ_W-1:0];

            r_side2.pix   <= r_pix1;
            // radius zero only matches the exact key and always replaces outright
            r_side2.hard  <= !i_bypass && w_match && (!i_soft_blend || w_rad_zero);
            r_side2.blend <= !i_bypass && w_match && i_soft_blend && !w_rad_zero;
            r_dist2       <= w_sum;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_dist2 = r_dist2;

    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> !(r_side2.hard && r_side2.blend))
        else $error("hard and soft replace both set");

endmodule

@@ hw/rtl/prc_sqrt.sv @@
// prc_sqrt: pipelined integer square root of dist2 * 2^32, one root bit per stage.
// Depends on prc_pkg.

module prc_sqrt
    import prc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [DIST_W-1:0] i_dist2,
    output logic              o_valid,
    output t_side             o_side,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_valid [SQRT_STEPS];
    t_side             r_side  [SQRT_STEPS];
    logic [DIST_W-1:0] r_src   [SQRT_STEPS];   // operand pairs still to feed, msb first
    logic [REM_W-1:0]  r_rem   [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root  [SQRT_STEPS];

    logic [DIST_W-1:0] n_src  [SQRT_STEPS];
    logic [REM_W-1:0]  n_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] n_root [SQRT_STEPS];

    always_comb begin
        logic [DIST_W-1:0] v_src;
        logic [REM_W-1:0]  v_rem, v_acc, v_trial;
        logic [ROOT_W-1:0] v_root;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            if (k == 0) begin
                v_src  = i_dist2;
                v_rem  = '0;
                v_root = '0;
            end else begin
                v_src  = r_src[k-1];
                v_rem  = r_rem[k-1];
                v_root = r_root[k-1];
            end
            // low 32 operand bits are zero, so pairs run dry after the dist2 bits
            v_acc   = {v_rem[REM_W-3:0], v_src[DIST_W-1 -: 2]};
            v_trial = {{(REM_W-ROOT_W-2){1'b0}}, v_root, 2'b01};
            n_src[k] = {v_src[DIST_W-3:0], 2'b00};
            if (v_acc >= v_trial) begin
                n_rem[k]  = v_acc - v_trial;
                n_root[k] = {v_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = v_acc;
                n_root[k] = {v_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_adv) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_valid[k] <= (k == 0) ? i_valid : r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
                r_src[k]  <= n_src[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_valid = r_valid[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1];

    // restoring square root leaves remainder no larger than twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[SQRT_STEPS-1] |->
            r_rem[SQRT_STEPS-1] <= {{(REM_W-ROOT_W-1){1'b0}}, r_root[SQRT_STEPS-1], 1'b0})
        else $error("square root remainder out of range");

endmodule

@@ hw/rtl/prc_div.sv @@
// prc_div: pipelined restoring divide of the root by the match radius, one quotient bit per stage.
// Depends on prc_pkg.

module prc_div
    import prc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [RAD_W-1:0]  i_match_radius,
    output logic              o_valid,
    output t_side             o_side,
    output logic [P_W-1:0]    o_p
);

    logic             r_valid [DIV_STEPS];
    t_side            r_side  [DIV_STEPS];
    logic [P_W-1:0]   r_src   [DIV_STEPS];   // dividend bits still to shift in
    logic [RAD_W-1:0] r_rem   [DIV_STEPS];
    logic [P_W-1:0]   r_q     [DIV_STEPS];

    logic [P_W-1:0]   n_src [DIV_STEPS];
    logic [RAD_W-1:0] n_rem [DIV_STEPS];
    logic [P_W-1:0]   n_q   [DIV_STEPS];

    always_comb begin
        logic [P_W-1:0]   v_src, v_q;
        logic [RAD_W-1:0] v_rem;
        logic [RAD_W:0]   v_acc;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                // root <= radius * 2^16, so the top bits are already below the radius
                v_src = i_root[P_W-1:0];
                v_rem = {{(RAD_W-ROOT_W+P_W){1'b0}}, i_root[ROOT_W-1:P_W]};
                v_q   = '0;
            end else begin
                v_src = r_src[k-1];
                v_rem = r_rem[k-1];
                v_q   = r_q[k-1];
            end
            v_acc    = {v_rem, v_src[P_W-1]};
            n_src[k] = {v_src[P_W-2:0], 1'b0};
            if (v_acc >= {1'b0, i_match_radius}) begin
                n_rem[k] = RAD_W'(v_acc - {1'b0, i_match_radius});
                n_q[k]   = {v_q[P_W-2:0], 1'b1};
            end else begin
                n_rem[k] = v_acc[RAD_W-1:0];
                n_q[k]   = {v_q[P_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_adv) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_valid[k] <= (k == 0) ? i_valid : r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
                r_src[k]  <= n_src[k];
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];
    assign o_p     = r_q[DIV_STEPS-1];

    a_p_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[DIV_STEPS-1] && r_side[DIV_STEPS-1].blend) |-> r_q[DIV_STEPS-1] <= P_ONE)
        else $error("blend factor above one");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[DIV_STEPS-1] && r_side[DIV_STEPS-1].blend) |->
            r_rem[DIV_STEPS-1] < i_match_radius)
        else $error("divide remainder not below radius");

endmodule

@@ hw/rtl/prc_blend.sv @@
// prc_blend: factor times channel difference, then add target and select the result word.
// Depends on prc_pkg. Last stage is the output register.

module prc_blend
    import prc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic [P_W-1:0]     i_p,
    input  logic [COLOR_W-1:0] i_new_color,
    output logic               o_valid,
    output t_out_word          o_word
);

    function automatic logic signed [PROD_W-1:0] scale(
        input logic [P_W-1:0]  p,
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] t
    );
        logic signed [DIFF_W-1:0] diff;
        diff  = $signed({1'b0, c}) - $signed({1'b0, t});
        scale = $signed({1'b0, p}) * diff;
    endfunction

    function automatic logic [CH_W-1:0] finish(
        input logic signed [PROD_W-1:0] prod,
        input logic [CH_W-1:0]          t
    );
        logic signed [NUM_W-1:0] num;
        num = $signed({{(NUM_W-CH_W-FRAC_W){1'b0}}, t, {FRAC_W{1'b0}}})
            + $signed({{(NUM_W-PROD_W){prod[PROD_W-1]}}, prod});
        finish = num[NUM_W-1] ? '0 : num[FRAC_W +: CH_W];
    endfunction

    logic                     r_v1;
    t_side                    r_side1;
    logic signed [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;

    logic                     r_valid;
    t_out_word                r_word;
    t_out_word                n_word;

    logic [CH_W-1:0] w_tr, w_tg, w_tb;

    assign w_tr = i_new_color[23:16];
    assign w_tg = i_new_color[15:8];
    assign w_tb = i_new_color[7:0];

    always_comb begin
        n_word.out_alpha = r_side1.pix.in_alpha;
        if (r_side1.blend) begin
            n_word.out_red   = finish(r_prod_r, w_tr);
            n_word.out_green = finish(r_prod_g, w_tg);
            n_word.out_blue  = finish(r_prod_b, w_tb);
        end else if (r_side1.hard) begin
            n_word.out_red   = w_tr;
            n_word.out_green = w_tg;
            n_word.out_blue  = w_tb;
        end else begin
            n_word.out_red   = r_side1.pix.in_red;
            n_word.out_green = r_side1.pix.in_green;
            n_word.out_blue  = r_side1.pix.in_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_v1    <= i_valid;
            r_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side1  <= i_side;
            r_prod_r <= scale(i_p, i_side.pix.in_red, w_tr);
            r_prod_g <= scale(i_p, i_side.pix.in_green, w_tg);
            r_prod_b <= scale(i_p, i_side.pix.in_blue, w_tb);
            r_word   <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ hw/rtl/pixel_color_replace.sv @@
// pixel_color_replace: top level, configuration registers, pipeline advance and stage chain.
// Depends on prc_pkg, prc_dist, prc_sqrt, prc_div, prc_blend.
//
// Channel  Dir  Handshake         Payload
// pixel    in   i_valid, o_stall  i_word (t_in_word)
// result   out  o_valid, i_stall  o_word (t_out_word)
// config   in   i_cfg_we          i_cfg_idx, i_cfg_data
//
// One word per clock while the output word is not stalled.
// The chain holds the square root (25 stages, one root bit each) and the divider
// (17 stages, one quotient bit each), plus 2 distance and 2 blend stages.
// The whole pipe advances together; it holds only while the output word is stalled.
// Synchronous reset clears valid bits and loads register defaults; nothing to sweep.

module pixel_color_replace
    import prc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [COLOR_W-1:0] r_key_color;
    logic [COLOR_W-1:0] r_new_color;
    logic [RAD_W-1:0]   r_match_radius;
    logic               r_soft_blend;
    logic               r_bypass;

    logic w_adv;

    logic              w_dist_valid;
    t_side             w_dist_side;
    logic [DIST_W-1:0] w_dist2;

    logic              w_sqrt_valid;
    t_side             w_sqrt_side;
    logic [ROOT_W-1:0] w_root;

    logic              w_div_valid;
    t_side             w_div_side;
    logic [P_W-1:0]    w_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color    <= '0;
            r_new_color    <= '0;
            r_match_radius <= RAD_W'(1);
            r_soft_blend   <= 1'b1;
            r_bypass       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_COLOR:    r_key_color    <= i_cfg_data[COLOR_W-1:0];
                CFG_NEW_COLOR:    r_new_color    <= i_cfg_data[COLOR_W-1:0];
                CFG_MATCH_RADIUS: r_match_radius <= i_cfg_data[RAD_W-1:0];
                CFG_SOFT_BLEND:   r_soft_blend   <= i_cfg_data[0];
                CFG_BYPASS:       r_bypass       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipe moves unless a finished word sits unaccepted
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    prc_dist u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (i_valid),
        .i_word         (i_word),
        .i_key_color    (r_key_color),
        .i_match_radius (r_match_radius),
        .i_soft_blend   (r_soft_blend),
        .i_bypass       (r_bypass),
        .o_valid        (w_dist_valid),
        .o_side         (w_dist_side),
        .o_dist2        (w_dist2)
    );

    prc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_dist_valid),
        .i_side  (w_dist_side),
        .i_dist2 (w_dist2),
        .o_valid (w_sqrt_valid),
        .o_side  (w_sqrt_side),
        .o_root  (w_root)
    );

    prc_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (w_sqrt_valid),
        .i_side         (w_sqrt_side),
        .i_root         (w_root),
        .i_match_radius (r_match_radius),
        .o_valid        (w_div_valid),
        .o_side         (w_div_side),
        .o_p            (w_p)
    );

    prc_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (w_div_valid),
        .i_side      (w_div_side),
        .i_p         (w_p),
        .i_new_color (r_new_color),
        .o_valid     (o_valid),
        .o_word      (o_word)
    );

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input held without a stalled output word");

endmodule
